FILE: hdl/sliding_window_spread_counter_top_defines.svh
// assertion macros shared by the spread counter checker
`ifndef SLIDING_WINDOW_SPREAD_COUNTER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_SPREAD_COUNTER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SWSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication checked on every clock edge, reset included
`define SWSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/swsc_pkg.sv
// shared types and constants of the sliding window spread counter
package swsc_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LIMIT_W  = 32;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned TOTAL_W  = 48;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // input transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_req;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [LEN_W-1:0]   window_length;
    logic [TOTAL_W-1:0] running_total;
    logic               capped;
  } out_t;

  // top-of-stack summary: running min and max, valid when the stack is not empty
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
  } top_t;

endpackage

FILE: hdl/swsc_ram.sv
// generic simple dual-port ram with registered read
module swsc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/swsc_spread.sv
// spread check over the two stack tops against the limit
module swsc_spread (
  input  swsc_pkg::top_t                  front_i,
  input  swsc_pkg::top_t                  back_i,
  input  logic [swsc_pkg::LIMIT_W-1:0]    limit_i,
  output logic                            good_o
);
  import swsc_pkg::*;

  logic signed [SAMPLE_W-1:0] hi;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W:0]   diff;

  // merge the two tops, an empty stack takes no part
  always_comb begin
    hi = front_i.hi;
    lo = front_i.lo;
    if (back_i.valid) begin
      if (!front_i.valid || back_i.hi > hi) begin
        hi = back_i.hi;
      end
      if (!front_i.valid || back_i.lo < lo) begin
        lo = back_i.lo;
      end
    end
  end

  // exact 33-bit spread, never negative while a stack holds samples
  assign diff = $signed({hi[SAMPLE_W-1], hi}) - $signed({lo[SAMPLE_W-1], lo});

  assign good_o = !(front_i.valid || back_i.valid) ||
                  (diff[SAMPLE_W:0] <= {1'b0, limit_i});

endmodule

FILE: hdl/sliding_window_spread_counter_top.sv
// top level of the sliding window spread counter
// A stream of signed samples feeds a window held as a queue of two stacks, each entry of the
// front stack carrying the running min and max below it. One transaction in gives one
// transaction out: the window length after the oldest samples have left until max minus min
// is within spread_limit, a running total saturating at 2^48-1, and a flag when a full window
// forced a drop. The block works on one sample at a time. A sample passes through accept, depth
// check, push, spread check and result. Each sample that leaves the window for the spread limit
// adds a pop, a re-read of the new front top from the front ram and a fresh spread check, with no
// re-read when the front stack empties; the drop forced by a full window adds a pop and the
// re-read, again with no re-read when the front stack empties. A move of the back stack onto the
// front stack reads each back ram entry ahead of its write into the front ram, overlapping reads
// with writes. Each sample moves and leaves at most once, which bounds the amortised work. A
// stalled result holds the block in its result state until the output register frees. No
// clearing pass is needed after reset. spread_limit may be written at any time the block is idle.
module sliding_window_spread_counter_top #(
  parameter int unsigned WINDOW_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  swsc_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output swsc_pkg::out_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swsc_pkg::LIMIT_W-1:0] cfg_data_i
);
  import swsc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CAP      = 8'b0000_0010,
    S_PUSH     = 8'b0000_0100,
    S_CHECK    = 8'b0000_1000,
    S_XFER     = 8'b0001_0000,
    S_POP      = 8'b0010_0000,
    S_POP_WAIT = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]          fc_q, fc_d;
  logic [CNT_W-1:0]          bc_q, bc_d;
  logic [TOTAL_W-1:0]        total_q, total_d;
  logic                      capped_q, capped_d;
  logic                      in_check_q, in_check_d;
  logic                      rd_pend_q, rd_pend_d;
  logic [LIMIT_W-1:0]        limit_q, limit_d;
  logic                      out_valid_q, out_valid_d;
  out_t                      out_data_q, out_data_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] ftop_lo_q, ftop_lo_d, ftop_hi_q, ftop_hi_d;
  logic signed [SAMPLE_W-1:0] btop_lo_q, btop_lo_d, btop_hi_q, btop_hi_d;

  // ram ports
  logic                      b_we, b_re;
  logic [ADDR_W-1:0]         b_waddr, b_raddr;
  logic [SAMPLE_W-1:0]       b_rdata;
  logic                      f_we, f_re;
  logic [ADDR_W-1:0]         f_waddr, f_raddr;
  logic [2*SAMPLE_W-1:0]     f_wdata, f_rdata;

  top_t                      front_top, back_top;
  logic                      good;
  logic                      accept;
  logic [CNT_W:0]            cnt_sum;
  logic [CNT_W-1:0]          len;
  logic [CNT_W-1:0]          bc_m1, fc_m2;
  logic [TOTAL_W:0]          total_sum;
  logic signed [SAMPLE_W-1:0] xv, xlo, xhi;
  state_e                    drop_state, ret_state;

  // back stack values
  swsc_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (sample_q),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // front stack running max and min
  swsc_ram #(.WIDTH(2 * SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  // spread of the whole window from the cached stack tops
  assign front_top = '{valid: (fc_q != '0), lo: ftop_lo_q, hi: ftop_hi_q};
  assign back_top  = '{valid: (bc_q != '0), lo: btop_lo_q, hi: btop_hi_q};

  swsc_spread u_spread (
    .front_i (front_top),
    .back_i  (back_top),
    .limit_i (limit_q),
    .good_o  (good)
  );

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // counts, addresses and sums
  assign cnt_sum   = (CNT_W+1)'(fc_q) + (CNT_W+1)'(bc_q);
  assign len       = fc_q + bc_q;
  assign bc_m1     = bc_q - CNT_W'(1);
  assign fc_m2     = fc_q - CNT_W'(2);
  assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(len);

  // next stage of a removal and where it returns to
  assign drop_state = (fc_q == '0) ? S_XFER : S_POP;
  assign ret_state  = in_check_q ? S_CHECK : S_PUSH;

  // sample moving from back ram into front stack
  assign xv  = $signed(b_rdata);
  assign xlo = (fc_q != '0 && ftop_lo_q < xv) ? ftop_lo_q : xv;
  assign xhi = (fc_q != '0 && ftop_hi_q > xv) ? ftop_hi_q : xv;

  // sequencer
  always_comb begin
    state_d     = state_q;
    fc_d        = fc_q;
    bc_d        = bc_q;
    total_d     = total_q;
    capped_d    = capped_q;
    in_check_d  = in_check_q;
    rd_pend_d   = rd_pend_q;
    ftop_lo_d   = ftop_lo_q;
    ftop_hi_d   = ftop_hi_q;
    btop_lo_d   = btop_lo_q;
    btop_hi_d   = btop_hi_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    limit_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : limit_q;
    b_we        = 1'b0;
    b_waddr     = bc_q[ADDR_W-1:0];
    b_re        = 1'b0;
    b_raddr     = bc_m1[ADDR_W-1:0];
    f_we        = 1'b0;
    f_waddr     = fc_q[ADDR_W-1:0];
    f_wdata     = {xhi, xlo};
    f_re        = 1'b0;
    f_raddr     = fc_m2[ADDR_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          capped_d = 1'b0;
          if (in_data_i.start_req) begin
            fc_d    = '0;
            bc_d    = '0;
            total_d = '0;
          end
          state_d = S_CAP;
        end
      end
      // full window: oldest sample leaves before the push
      S_CAP: begin
        if (cnt_sum >= (CNT_W+1)'(WINDOW_DEPTH)) begin
          capped_d   = 1'b1;
          in_check_d = 1'b0;
          rd_pend_d  = 1'b0;
          state_d    = drop_state;
        end else begin
          state_d = S_PUSH;
        end
      end
      // push onto the back stack, running min and max kept in registers
      S_PUSH: begin
        b_we = 1'b1;
        if (bc_q == '0) begin
          btop_lo_d = sample_q;
          btop_hi_d = sample_q;
        end else begin
          btop_lo_d = (btop_lo_q < sample_q) ? btop_lo_q : sample_q;
          btop_hi_d = (btop_hi_q > sample_q) ? btop_hi_q : sample_q;
        end
        bc_d       = bc_q + CNT_W'(1);
        in_check_d = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        rd_pend_d = 1'b0;
        if (good) begin
          state_d = S_OUT;
        end else begin
          state_d = drop_state;
        end
      end
      // move the back stack onto the front stack, each write uses the read issued in the cycle before
      S_XFER: begin
        if (rd_pend_q) begin
          f_we      = 1'b1;
          ftop_lo_d = xlo;
          ftop_hi_d = xhi;
          fc_d      = fc_q + CNT_W'(1);
        end
        if (bc_q != '0) begin
          b_re      = 1'b1;
          bc_d      = bc_m1;
          rd_pend_d = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            state_d = S_POP;
          end
        end
      end
      // drop the oldest sample, fetch the new front top unless the front stack is left empty
      S_POP: begin
        fc_d = fc_q - CNT_W'(1);
        if (fc_q >= CNT_W'(2)) begin
          f_re    = 1'b1;
          state_d = S_POP_WAIT;
        end else begin
          state_d = ret_state;
        end
      end
      S_POP_WAIT: begin
        ftop_hi_d = $signed(f_rdata[2*SAMPLE_W-1:SAMPLE_W]);
        ftop_lo_d = $signed(f_rdata[SAMPLE_W-1:0]);
        state_d   = ret_state;
      end
      // result waits for a free output register
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          total_d                  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
          out_valid_d              = 1'b1;
          out_data_d.window_length = LEN_W'(len);
          out_data_d.running_total = total_d;
          out_data_d.capped        = capped_q;
          state_d                  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fc_q        <= '0;
      bc_q        <= '0;
      total_q     <= '0;
      capped_q    <= 1'b0;
      in_check_q  <= 1'b0;
      rd_pend_q   <= 1'b0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      bc_q        <= bc_d;
      total_q     <= total_d;
      capped_q    <= capped_d;
      in_check_q  <= in_check_d;
      rd_pend_q   <= rd_pend_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_data_i.sample;
    end
    ftop_lo_q  <= ftop_lo_d;
    ftop_hi_q  <= ftop_hi_d;
    btop_lo_q  <= btop_lo_d;
    btop_hi_q  <= btop_hi_d;
    out_data_q <= out_data_d;
  end

endmodule

FILE: hdl/swsc_checker.sv
// port-level checker of the spread counter and its bind
`include "sliding_window_spread_counter_top_defines.svh"

module swsc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input swsc_pkg::out_t               out_data_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o
);
  import swsc_pkg::*;

  // a stalled result holds
  `SWSC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // one sample at a time: busy right after an accepted transaction
  `SWSC_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "input taken while busy")

  // a new result never appears in the cycle after an accept
  `SWSC_ASSERT(a_no_instant_result, in_valid_i && !in_stall_o |=> !$rose(out_valid_o), "result too early")

  // a result is only produced while a sample is being worked on
  `SWSC_ASSERT(a_result_from_work, $rose(out_valid_o) |-> $past(in_stall_o), "result without work")

  // the register port never back-pressures
  `SWSC_ASSERT_ALWAYS(a_cfg_ready, cfg_valid_i |-> cfg_ready_o, "configuration write refused")

endmodule

bind sliding_window_spread_counter_top swsc_checker u_swsc_checker (.*);

FILE: dv/sliding_window_spread_counter_top_tb.sv
// self-checking testbench for the sliding window spread counter
module sliding_window_spread_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swsc_pkg::*;

  localparam int unsigned DEPTH        = 1024;
  localparam int          ITEMS_TARGET = 1650;
  localparam int          PLAN_ROWS    = 24;
  localparam logic [31:0] SMAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN         = 32'h8000_0000;
  localparam logic [31:0] LIM_MAX      = 32'hFFFF_FFFF;

  // one row of the directed sequence
  typedef struct {
    bit          set_lim;
    logic [31:0] lim;
    logic [31:0] sample;
    bit          start;
    bit          known;
    int          len;
    longint      tot;
    bit          cap;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [LIMIT_W-1:0]  cfg_data_i;

  // predictor state: the window as a plain queue of samples, oldest first
  int                  window_q[$];
  logic [TOTAL_W-1:0]  window_total;
  logic [LIMIT_W-1:0]  window_limit;

  out_t                due_results[$];
  plan_row_t           plan [PLAN_ROWS];

  int                  err_cnt;
  int                  n_items;
  int                  n_results;
  int                  n_capped;
  int                  n_lim_writes;
  int                  longest_window;
  bit                  idle_on;
  bit                  stall_on;

  sliding_window_spread_counter_top #(
    .WINDOW_DEPTH(DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run time limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // add one sample to the window, trim to the spread limit, update the total
  function automatic out_t advance_window(input in_t item);
    out_t             r;
    longint           hi;
    longint           lo;
    longint           lim;
    logic [TOTAL_W:0] sum;
    r = '0;
    lim = longint'(window_limit);
    if (item.start_req) begin
      window_q.delete();
      window_total = '0;
    end
    // full window loses its oldest sample first
    if (window_q.size() >= DEPTH) begin
      void'(window_q.pop_front());
      r.capped = 1'b1;
    end
    window_q.insert(window_q.size(), item.sample);
    // oldest samples leave until max minus min fits the limit
    forever begin
      hi = longint'(window_q[0]);
      lo = longint'(window_q[0]);
      foreach (window_q[i]) begin
        if (window_q[i] > hi) hi = longint'(window_q[i]);
        if (window_q[i] < lo) lo = longint'(window_q[i]);
      end
      if (hi - lo <= lim) break;
      void'(window_q.pop_front());
    end
    sum = {1'b0, window_total} + (TOTAL_W+1)'(window_q.size());
    window_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    r.window_length = LEN_W'(window_q.size());
    r.running_total = window_total;
    return r;
  endfunction

  // offer one sample after a random gap, predict on acceptance
  task automatic drive_sample(input in_t item, output out_t predicted);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_window(item);
    n_items++;
    if (predicted.capped) n_capped++;
    if (int'(predicted.window_length) > longest_window) begin
      longest_window = int'(predicted.window_length);
    end
  endtask

  // stop offering samples and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  // spread limit write, only with the block idle
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i  <= 1'b0;
    window_limit = value;
    n_lim_writes++;
  endtask

  // result side: random stall before each transaction, then compare
  initial begin : result_check
    int   stall_cycles;
    out_t want;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall_cycles = stall_on ? $urandom_range(0, 7) : 0;
      if (stall_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      n_results++;
      if (due_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, got len %0d total %0d capped %0b",
                 $time, out_data_o.window_length, out_data_o.running_total,
                 out_data_o.capped);
      end else begin
        want = due_results.pop_front();
        if (out_data_o.window_length !== want.window_length) begin
          err_cnt++;
          $display("%0t: window_length expected %0d got %0d", $time,
                   want.window_length, out_data_o.window_length);
        end
        if (out_data_o.running_total !== want.running_total) begin
          err_cnt++;
          $display("%0t: running_total expected %0d got %0d", $time,
                   want.running_total, out_data_o.running_total);
        end
        if (out_data_o.capped !== want.capped) begin
          err_cnt++;
          $display("%0t: capped expected %0b got %0b", $time, want.capped, out_data_o.capped);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    in_t         item;
    out_t        predicted;
    out_t        typed;
    logic [31:0] lim;
    int          run_len;
    int          mode;
    int          base;
    int          spread_w;
    int          phase;

    err_cnt        = 0;
    n_items        = 0;
    n_results      = 0;
    n_capped       = 0;
    n_lim_writes   = 0;
    longest_window = 0;
    idle_on        = 1'b1;
    stall_on       = 1'b1;
    window_total   = '0;
    window_limit   = '0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;

    // extremes, wrap of the 33-bit spread, multi-sample drops, restarts
    plan = '{
      '{0, 0,           32'h0000_0000, 1, 1, 1, 1,  0},  // first sample after reset
      '{0, 0,           32'h0000_0000, 0, 1, 2, 3,  0},
      '{0, 0,           SMAX,          0, 1, 1, 4,  0},
      '{0, 0,           SMIN,          0, 1, 1, 5,  0},
      '{0, 0,           SMIN,          0, 1, 2, 7,  0},
      '{0, 0,           32'hFFFF_FFFF, 1, 1, 1, 1,  0},
      '{0, 0,           32'hFFFF_FFFF, 0, 1, 2, 3,  0},
      '{1, LIM_MAX,     SMAX,          1, 1, 1, 1,  0},  // widest limit keeps everything
      '{0, 0,           SMIN,          0, 1, 2, 3,  0},
      '{0, 0,           32'h0000_0000, 0, 1, 3, 6,  0},
      '{0, 0,           SMAX,          0, 1, 4, 10, 0},
      '{1, LIM_MAX - 1, SMIN,          1, 1, 1, 1,  0},  // full-scale spread one too wide
      '{0, 0,           SMAX,          0, 1, 1, 2,  0},
      '{0, 0,           32'h7FFF_FFFE, 0, 1, 2, 4,  0},
      '{0, 0,           SMIN,          0, 1, 2, 6,  0},
      '{1, 5,           32'd100,       1, 0, 0, 0,  0},
      '{0, 0,           32'd103,       0, 0, 0, 0,  0},
      '{0, 0,           32'd105,       0, 0, 0, 0,  0},
      '{0, 0,           32'd98,        0, 0, 0, 0,  0},  // several samples leave at once
      '{0, 0,           32'hFFFF_FFFD, 0, 0, 0, 0,  0},
      '{0, 0,           32'd2,         0, 0, 0, 0,  0},
      '{1, 1,           32'h5555_5555, 1, 0, 0, 0,  0},
      '{0, 0,           32'h5555_5556, 0, 0, 0, 0,  0},
      '{0, 0,           32'hAAAA_AAAA, 0, 0, 0, 0,  0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].set_lim) write_limit(plan[i].lim);
      item.sample    = plan[i].sample;
      item.start_req = plan[i].start;
      drive_sample(item, predicted);
      typed.window_length = LEN_W'(plan[i].len);
      typed.running_total = TOTAL_W'(plan[i].tot);
      typed.capped        = plan[i].cap;
      due_results.insert(due_results.size(), plan[i].known ? typed : predicted);
    end

    // random phases: one long run past full depth, then short mixed ones
    phase = 0;
    while (n_items < ITEMS_TARGET) begin
      if (phase == 0) begin
        lim     = LIM_MAX;
        run_len = DEPTH + 76;
        mode    = 0;
      end else begin
        case ($urandom_range(0, 5))
          0:       lim = '0;
          1:       lim = LIM_MAX;
          2:       lim = $urandom_range(0, 16);
          3:       lim = (32'd1 << $urandom_range(0, 31)) - 32'd1;
          4:       lim = $urandom;
          default: lim = LIM_MAX - 1;
        endcase
        run_len = $urandom_range(20, 80);
        mode    = $urandom_range(0, 2);
      end
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      write_limit(lim);
      base     = $urandom;
      spread_w = $urandom_range(0, 12);
      for (int k = 0; k < run_len; k++) begin
        if (k == 0) item.start_req = (phase == 0) || ($urandom_range(0, 1) == 1);
        else        item.start_req = (phase != 0) && ($urandom_range(0, 31) == 0);
        case (mode)
          0: item.sample = $urandom;
          // slow walk around a base value, with the odd jump
          1: begin
            if ($urandom_range(0, 15) == 0) base = $urandom;
            base = base + int'($urandom_range(0, 2 * spread_w)) - spread_w;
            item.sample = base;
          end
          default: begin
            case ($urandom_range(0, 4))
              0:       item.sample = SMAX;
              1:       item.sample = SMIN;
              2:       item.sample = '0;
              3:       item.sample = 32'hFFFF_FFFF;
              default: item.sample = $urandom;
            endcase
          end
        endcase
        drive_sample(item, predicted);
        due_results.insert(due_results.size(), predicted);
      end
      phase++;
    end

    // wind down
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("run covered %0d samples in %0d phases, %0d results, %0d limit writes",
             n_items, phase, n_results, n_lim_writes);
    $display("longest window %0d, %0d samples forced out by the depth limit",
             longest_window, n_capped);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/swsc_pkg.sv
hdl/swsc_ram.sv
hdl/swsc_spread.sv
hdl/sliding_window_spread_counter_top.sv
hdl/swsc_checker.sv
dv/sliding_window_spread_counter_top_tb.sv
